FILE: rtl/mfeu_pkg.sv
// ----------------------------------------------------------------------------
// mfeu_pkg: shared definitions for the encoder unwrap core
// Constants, control word layout and the microprogram of the sequencer.
// ----------------------------------------------------------------------------
package mfeu_pkg;

  localparam int CALIB_FRAMES    = 50;
  localparam int COUNTS_PER_TURN = 8192;
  localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
  localparam int TURN_SHIFT      = $clog2(COUNTS_PER_TURN);

  localparam int FC_W    = 6;
  localparam int POS_W   = 16;
  localparam int TURNS_W = 32;
  localparam int DELTA_W = 15;
  localparam int DIFF_W  = 18;
  localparam int TOTAL_W = 48;
  localparam int CPU_W   = 16;
  localparam int DIV_CNT_W = $clog2(TOTAL_W);

  localparam int DELTA_MAX = (1 << (DELTA_W - 1)) - 1;
  localparam int DELTA_MIN = -(1 << (DELTA_W - 1));

  localparam logic [CPU_W-1:0] CPU_RESET = 16'd432;

  // Microprogram steps.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_TOTAL = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LOAD  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIV   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RETRY = 3'd5;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DIV_MORE,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic              accept;
    logic              calc_total;
    div_ctrl_t         div;
    logic              emit;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Microprogram ROM: one control word per step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{accept: 1'b0, calc_total: 1'b0, div: '{load: 1'b0, step: 1'b0},
          emit: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_TOTAL: begin
        w.calc_total = 1'b1;
        w.cond       = COND_NEXT;
      end
      STEP_LOAD: begin
        w.div.load = 1'b1;
        w.cond     = COND_NEXT;
      end
      STEP_DIV: begin
        w.div.step = 1'b1;
        w.cond     = COND_DIV_MORE;
        w.target   = STEP_DIV;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.target = STEP_IDLE;
      end
      STEP_RETRY: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_EMIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/mfeu_div.sv
// ----------------------------------------------------------------------------
// mfeu_div: bit-serial unsigned divider
// Restoring division of a 48-bit magnitude by a 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module mfeu_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mfeu_pkg::div_ctrl_t       ctrl_i,
  input  logic [mfeu_pkg::TOTAL_W-1:0] dividend_i,
  input  logic [mfeu_pkg::CPU_W-1:0]   divisor_i,
  output logic [mfeu_pkg::TOTAL_W-1:0] quotient_o,
  output logic                      more_o
);
  import mfeu_pkg::*;

  logic [TOTAL_W-1:0]   quot_q, quot_d;
  logic [CPU_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CPU_W:0]       rem_sh;
  logic [CPU_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, quot_q[TOTAL_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (ctrl_i.load) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(TOTAL_W - 1);
    end else if (ctrl_i.step) begin
      quot_d = {quot_q[TOTAL_W-2:0], ge};
      rem_d  = ge ? rem_sub[CPU_W-1:0] : rem_sh[CPU_W-1:0];
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign quotient_o = quot_q;
  assign more_o     = cnt_q != '0;

endmodule

FILE: rtl/motor_feedback_encoder_unwrap_core.sv
// ----------------------------------------------------------------------------
// motor_feedback_encoder_unwrap_core: motor feedback frame decoder
// Decodes a feedback frame, unwraps the 13-bit encoder into a multi-turn
// count and scales the total count into angle units.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one seven-byte feedback frame per request
// (in_valid_i / in_stall_o); the output channel returns exactly one decoded
// request per frame (out_valid_o / out_stall_i). A request moves at a rising
// edge where valid is high and stall is low.
// A microcoded sequencer runs each frame: the idle step takes the frame and
// updates the unwrap state, the next steps form the total count and load the
// divider, the bit-serial divider then works out all 48 quotient bits, and the
// emit step writes the output register. The input stalls outside the idle
// step, so a new frame is taken only once the last one has been emitted.
// The output register parts the two sides: a new frame is taken while a
// finished result still waits. If the receiver stalls, the sequencer loops
// between the emit and retry steps until the output register is free.
// After reset the first 50 frames only capture the zero offset and are
// flagged as calibrating; counts_per_unit resets to 432.
// ----------------------------------------------------------------------------
module motor_feedback_encoder_unwrap_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: counts_per_unit
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  // Frame input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          pos_high_i,
  input  logic [7:0]          pos_low_i,
  input  logic [7:0]          speed_high_i,
  input  logic [7:0]          speed_low_i,
  input  logic [7:0]          current_high_i,
  input  logic [7:0]          current_low_i,
  input  logic [7:0]          temperature_i,
  // Decoded output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                calibrating_o,
  output logic [15:0]         position_o,
  output logic signed [15:0]  speed_o,
  output logic signed [15:0]  current_o,
  output logic [7:0]          temp_out_o,
  output logic signed [14:0]  step_delta_o,
  output logic signed [31:0]  turn_count_o,
  output logic signed [47:0]  total_count_o,
  output logic signed [47:0]  angle_o
);
  import mfeu_pkg::*;

  // Sequencer.
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            cw;
  logic              jump;
  logic              div_more;
  logic              out_free;
  logic              take;
  logic              do_emit;

  // Configuration.
  logic [CPU_W-1:0] cpu_q;

  // Unwrap state.
  logic [FC_W-1:0]          fc_q, fc_d;
  logic [POS_W-1:0]         last_pos_q, last_pos_d;
  logic [POS_W-1:0]         zero_off_q, zero_off_d;
  logic [TURNS_W-1:0]       turns_q, turns_d;
  logic [15:0]              speed_q, speed_d;
  logic [15:0]              current_q, current_d;
  logic [7:0]               temp_q, temp_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  logic                     calib_q, calib_d;
  logic [TOTAL_W-1:0]       total_q;

  // Frame decode and unwrap.
  logic [POS_W-1:0]          pos_w;
  logic                      calib_w;
  logic signed [DIFF_W-1:0]  diff_w;
  logic signed [DIFF_W-1:0]  adj_w;

  // Division.
  logic [TOTAL_W-1:0] total_w;
  logic [TOTAL_W-1:0] mag_w;
  logic [TOTAL_W-1:0] quot_w;
  logic [TOTAL_W-1:0] angle_w;

  // Output register.
  logic               out_valid_q;
  logic               o_calib_q;
  logic [15:0]        o_pos_q;
  logic [15:0]        o_speed_q;
  logic [15:0]        o_current_q;
  logic [7:0]         o_temp_q;
  logic [DELTA_W-1:0] o_delta_q;
  logic [TURNS_W-1:0] o_turns_q;
  logic [TOTAL_W-1:0] o_total_q;
  logic [TOTAL_W-1:0] o_angle_q;

  div_ctrl_t div_ctrl;

  // The control word of the current step drives the whole datapath.
  assign cw       = ucode_rom(step_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = cw.accept && in_valid_i;
  assign do_emit  = cw.emit && out_free;
  assign in_stall_o = !cw.accept;

  always_comb begin
    case (cw.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_INPUT: jump = !in_valid_i;
      COND_DIV_MORE: jump = div_more;
      COND_OUT_FREE: jump = out_free;
      default:       jump = 1'b1;
    endcase
    step_d = jump ? cw.target : step_q + 1'b1;
  end

  // A frame is a calibration frame while fewer than CALIB_FRAMES have been
  // seen; the counter then holds. Outside calibration a jump of more than
  // half a turn is read as an encoder wrap.
  assign pos_w   = {pos_high_i, pos_low_i};
  assign calib_w = fc_q < FC_W'(CALIB_FRAMES);
  assign diff_w  = $signed({2'b00, pos_w}) - $signed({2'b00, last_pos_q});

  always_comb begin
    fc_d       = fc_q;
    last_pos_d = last_pos_q;
    zero_off_d = zero_off_q;
    turns_d    = turns_q;
    speed_d    = speed_q;
    current_d  = current_q;
    temp_d     = temp_q;
    delta_d    = delta_q;
    calib_d    = calib_q;
    adj_w      = diff_w;
    if (diff_w > $signed(DIFF_W'(HALF_TURN))) begin
      adj_w = diff_w - $signed(DIFF_W'(COUNTS_PER_TURN));
    end else if (diff_w < -$signed(DIFF_W'(HALF_TURN))) begin
      adj_w = diff_w + $signed(DIFF_W'(COUNTS_PER_TURN));
    end
    if (take) begin
      calib_d    = calib_w;
      last_pos_d = pos_w;
      if (calib_w) begin
        fc_d       = fc_q + 1'b1;
        zero_off_d = pos_w;
      end else begin
        if (diff_w > $signed(DIFF_W'(HALF_TURN))) begin
          turns_d = turns_q - 1'b1;
        end else if (diff_w < -$signed(DIFF_W'(HALF_TURN))) begin
          turns_d = turns_q + 1'b1;
        end
        if (adj_w > $signed(DIFF_W'(DELTA_MAX))) begin
          delta_d = DELTA_W'(DELTA_MAX);
        end else if (adj_w < $signed(DIFF_W'(DELTA_MIN))) begin
          delta_d = DELTA_W'(DELTA_MIN);
        end else begin
          delta_d = adj_w[DELTA_W-1:0];
        end
        speed_d   = {speed_high_i, speed_low_i};
        current_d = {current_high_i, current_low_i};
        temp_d    = temperature_i;
      end
    end
  end

  // Total count since the offset, modulo 2^48.
  assign total_w = {{(TOTAL_W - TURNS_W - TURN_SHIFT){turns_q[TURNS_W-1]}},
                    turns_q, {TURN_SHIFT{1'b0}}}
                   + {{(TOTAL_W - POS_W){1'b0}}, last_pos_q}
                   - {{(TOTAL_W - POS_W){1'b0}}, zero_off_q};

  // The divider works on magnitudes; the sign is restored at emit time,
  // which gives truncation toward zero. A zero divisor reads as angle zero.
  assign mag_w   = total_q[TOTAL_W-1] ? -total_q : total_q;
  assign angle_w = (cpu_q == '0) ? '0
                 : (total_q[TOTAL_W-1] ? -quot_w : quot_w);

  assign div_ctrl.load = cw.div.load;
  assign div_ctrl.step = cw.div.step;

  mfeu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (mag_w),
    .divisor_i  (cpu_q),
    .quotient_o (quot_w),
    .more_o     (div_more)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      cpu_q       <= CPU_RESET;
      fc_q        <= '0;
      last_pos_q  <= '0;
      zero_off_q  <= '0;
      turns_q     <= '0;
      speed_q     <= '0;
      current_q   <= '0;
      temp_q      <= '0;
      delta_q     <= '0;
      calib_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q     <= step_d;
      fc_q       <= fc_d;
      last_pos_q <= last_pos_d;
      zero_off_q <= zero_off_d;
      turns_q    <= turns_d;
      speed_q    <= speed_d;
      current_q  <= current_d;
      temp_q     <= temp_d;
      delta_q    <= delta_d;
      calib_q    <= calib_d;
      if (cfg_we_i) begin
        cpu_q <= cfg_wdata_i;
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.calc_total) begin
      total_q <= total_w;
    end
    if (do_emit) begin
      o_calib_q   <= calib_q;
      o_pos_q     <= last_pos_q;
      o_speed_q   <= speed_q;
      o_current_q <= current_q;
      o_temp_q    <= temp_q;
      o_delta_q   <= delta_q;
      o_turns_q   <= turns_q;
      o_total_q   <= total_q;
      o_angle_q   <= angle_w;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign calibrating_o = o_calib_q;
  assign position_o    = o_pos_q;
  assign speed_o       = $signed(o_speed_q);
  assign current_o     = $signed(o_current_q);
  assign temp_out_o    = o_temp_q;
  assign step_delta_o  = $signed(o_delta_q);
  assign turn_count_o  = $signed(o_turns_q);
  assign total_count_o = $signed(o_total_q);
  assign angle_o       = $signed(o_angle_q);

endmodule

FILE: tb/sv/motor_feedback_encoder_unwrap_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_feedback_encoder_unwrap_core_tb: self-checking bench for the unwrap core
// Feeds feedback frames through the valid/stall input channel and checks every
// decoded request against a cycle-free model of the decoder. The run covers the
// offset capture frames, half-turn wrap boundaries, oversized jumps that
// saturate the delta, and several divisor settings including zero and the
// extremes. Both sides idle at random, and the receiver holds off once for a
// long stretch so that the core backs up into its input.
// ----------------------------------------------------------------------------
module motor_feedback_encoder_unwrap_core_tb;

  localparam int CALIB_N    = mfeu_pkg::CALIB_FRAMES;
  localparam int TURN_CNT   = mfeu_pkg::COUNTS_PER_TURN;
  localparam int HALF       = mfeu_pkg::HALF_TURN;
  localparam int SAT_HI     = mfeu_pkg::DELTA_MAX;
  localparam int SAT_LO     = mfeu_pkg::DELTA_MIN;

  localparam int IDLE_PCT       = 26;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 140;
  localparam int N_PHASES       = 6;
  localparam int N_VEC          = 18;

  // One decoded request as the core presents it on its output ports.
  typedef struct packed {
    logic        calib;
    logic [15:0] position;
    logic [15:0] speed;
    logic [15:0] current;
    logic [7:0]  temp;
    logic [14:0] delta;
    logic [31:0] turns;
    logic [47:0] total;
    logic [47:0] angle;
  } decoded_t;

  // A directed frame. When known is set the expected request is typed in the
  // row; when fill is set, random capture frames are sent first so that this
  // row lands on the last calibration frame.
  typedef struct packed {
    logic        known;
    logic        fill;
    logic [15:0] pos;
    logic [15:0] speed;
    logic [15:0] current;
    logic [7:0]  temp;
    decoded_t    want;
  } frame_vec_t;

  // Clock, reset and every input of the core start at known values.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [15:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic [7:0]  pos_high_i     = '0;
  logic [7:0]  pos_low_i      = '0;
  logic [7:0]  speed_high_i   = '0;
  logic [7:0]  speed_low_i    = '0;
  logic [7:0]  current_high_i = '0;
  logic [7:0]  current_low_i  = '0;
  logic [7:0]  temperature_i  = '0;
  logic        out_stall_i    = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic               calibrating_o;
  logic [15:0]        position_o;
  logic signed [15:0] speed_o;
  logic signed [15:0] current_o;
  logic [7:0]         temp_out_o;
  logic signed [14:0] step_delta_o;
  logic signed [31:0] turn_count_o;
  logic signed [47:0] total_count_o;
  logic signed [47:0] angle_o;

  // Typed expectation that travels alongside the payload of a directed row.
  logic     row_known  = 1'b0;
  decoded_t row_result = '0;

  // Shared controls between the stimulus and the receiver.
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  // Decoder model state, at the widths of the core.
  logic [5:0]  calib_seen;
  logic [15:0] prev_pos;
  logic [15:0] zero_pos;
  logic [31:0] turn_acc;
  logic [15:0] held_spd;
  logic [15:0] held_cur;
  logic [7:0]  held_tmp;
  logic [14:0] held_step;
  logic [15:0] cnt_per_unit;

  decoded_t pending_frames[$];
  int       mismatch_count = 0;
  int       frames_sent    = 0;
  int       stuck_cycles   = 0;

  // The directed table. The capture rows after reset can be read off at a
  // glance: only the position moves and everything else stays at zero. The
  // unwrap rows that follow are checked against the model.
  frame_vec_t vec_tab [N_VEC] = '{
    '{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00,
      '{1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'h0, 32'h0, 48'h0, 48'h0}},
    '{1'b1, 1'b0, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF,
      '{1'b1, 16'hFFFF, 16'h0000, 16'h0000, 8'h00, 15'h0, 32'h0, 48'h0, 48'h0}},
    '{1'b1, 1'b0, 16'h1FFF, 16'h8000, 16'h7FFF, 8'h01,
      '{1'b1, 16'h1FFF, 16'h0000, 16'h0000, 8'h00, 15'h0, 32'h0, 48'h0, 48'h0}},
    '{1'b1, 1'b0, 16'h2000, 16'hFFFF, 16'h0001, 8'h80,
      '{1'b1, 16'h2000, 16'h0000, 16'h0000, 8'h00, 15'h0, 32'h0, 48'h0, 48'h0}},
    '{1'b1, 1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55,
      '{1'b1, 16'hAAAA, 16'h0000, 16'h0000, 8'h00, 15'h0, 32'h0, 48'h0, 48'h0}},
    // Last capture frame: this position becomes the zero offset.
    '{1'b1, 1'b1, 16'h0064, 16'hFFFF, 16'hFFFF, 8'h7F,
      '{1'b1, 16'h0064, 16'h0000, 16'h0000, 8'h00, 15'h0, 32'h0, 48'h0, 48'h0}},
    // No motion, then exactly half a turn forward, which is not a wrap.
    '{1'b0, 1'b0, 16'h0064, 16'h7FFF, 16'h8000, 8'hFF, '0},
    '{1'b0, 1'b0, 16'h1064, 16'h8000, 16'h7FFF, 8'h00, '0},
    // One count past half a turn back wraps forward, then a wrap backward.
    '{1'b0, 1'b0, 16'h0063, 16'h0001, 16'hFFFF, 8'h01, '0},
    '{1'b0, 1'b0, 16'h1FFF, 16'hFFFF, 16'h0001, 8'h80, '0},
    // Exactly half a turn back, again no wrap.
    '{1'b0, 1'b0, 16'h0FFF, 16'h1234, 16'hCDEF, 8'h3C, '0},
    // Words wider than one turn: the delta saturates high, then low.
    '{1'b0, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 8'h00, '0},
    '{1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00, '0},
    // Single-count steps across the turn boundary in both directions.
    '{1'b0, 1'b0, 16'h1FFF, 16'h00FF, 16'hFF00, 8'hF0, '0},
    '{1'b0, 1'b0, 16'h0000, 16'hFF00, 16'h00FF, 8'h0F, '0},
    '{1'b0, 1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55, '0},
    '{1'b0, 1'b0, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA, '0},
    '{1'b0, 1'b0, 16'h1065, 16'h0000, 16'h0000, 8'h00, '0}
  };

  motor_feedback_encoder_unwrap_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pos_high_i     (pos_high_i),
    .pos_low_i      (pos_low_i),
    .speed_high_i   (speed_high_i),
    .speed_low_i    (speed_low_i),
    .current_high_i (current_high_i),
    .current_low_i  (current_low_i),
    .temperature_i  (temperature_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .calibrating_o  (calibrating_o),
    .position_o     (position_o),
    .speed_o        (speed_o),
    .current_o      (current_o),
    .temp_out_o     (temp_out_o),
    .step_delta_o   (step_delta_o),
    .turn_count_o   (turn_count_o),
    .total_count_o  (total_count_o),
    .angle_o        (angle_o)
  );

  always #5 clk_i = ~clk_i;

  // Decodes one accepted frame, updates the model state and returns the
  // request the core should produce for it.
  function automatic decoded_t decode_frame(input logic [15:0] pos, input logic [15:0] spd,
                                            input logic [15:0] cur, input logic [7:0] tmp);
    decoded_t    r;
    longint      diff;
    longint      step;
    longint      sum;
    longint      quot;
    logic [47:0] sum48;
    logic        calib;
    calib = (calib_seen < CALIB_N);
    if (calib) begin
      // Capture frames only move the offset; the counter stops at the end.
      calib_seen = calib_seen + 6'd1;
      prev_pos   = pos;
      zero_pos   = pos;
    end else begin
      // A jump of more than half a turn is taken as a wrap of the encoder.
      diff = longint'(pos) - longint'(prev_pos);
      if (diff > HALF) begin
        turn_acc = turn_acc - 32'd1;
        step     = diff - TURN_CNT;
      end else if (diff < -HALF) begin
        turn_acc = turn_acc + 32'd1;
        step     = diff + TURN_CNT;
      end else begin
        step = diff;
      end
      if (step > SAT_HI) step = SAT_HI;
      if (step < SAT_LO) step = SAT_LO;
      held_step = step[14:0];
      prev_pos  = pos;
      held_spd  = spd;
      held_cur  = cur;
      held_tmp  = tmp;
    end
    sum   = longint'($signed(turn_acc)) * TURN_CNT + longint'(prev_pos) - longint'(zero_pos);
    sum48 = sum[47:0];
    // Signed division truncates toward zero; a zero divisor gives zero.
    if (cnt_per_unit == 16'd0) begin
      quot = 0;
    end else begin
      quot = longint'($signed(sum48)) / longint'(cnt_per_unit);
    end
    r.calib    = calib;
    r.position = prev_pos;
    r.speed    = held_spd;
    r.current  = held_cur;
    r.temp     = held_tmp;
    r.delta    = held_step;
    r.turns    = turn_acc;
    r.total    = sum48;
    r.angle    = quot[47:0];
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input decoded_t w);
    if (calibrating_o !== w.calib)
      note_mismatch($sformatf("calibrating got %b want %b", calibrating_o, w.calib));
    if (position_o !== w.position)
      note_mismatch($sformatf("position got %h want %h", position_o, w.position));
    if (speed_o !== w.speed)
      note_mismatch($sformatf("speed got %h want %h", speed_o, w.speed));
    if (current_o !== w.current)
      note_mismatch($sformatf("current got %h want %h", current_o, w.current));
    if (temp_out_o !== w.temp)
      note_mismatch($sformatf("temp_out got %h want %h", temp_out_o, w.temp));
    if (step_delta_o !== w.delta)
      note_mismatch($sformatf("step_delta got %h want %h", step_delta_o, w.delta));
    if (turn_count_o !== w.turns)
      note_mismatch($sformatf("turn_count got %h want %h", turn_count_o, w.turns));
    if (total_count_o !== w.total)
      note_mismatch($sformatf("total_count got %h want %h", total_count_o, w.total));
    if (angle_o !== w.angle)
      note_mismatch($sformatf("angle got %h want %h", angle_o, w.angle));
  endtask

  // Offers one frame, with a random idle gap first, and returns at the edge
  // where the core takes it. Valid stays high from one frame to the next
  // when no gap is drawn.
  task automatic offer_frame(input logic [15:0] pos, input logic [15:0] spd,
                             input logic [15:0] cur, input logic [7:0] tmp,
                             input logic known, input decoded_t want);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pos_high_i     <= pos[15:8];
    pos_low_i      <= pos[7:0];
    speed_high_i   <= spd[15:8];
    speed_low_i    <= spd[7:0];
    current_high_i <= cur[15:8];
    current_low_i  <= cur[7:0];
    temperature_i  <= tmp;
    row_known      <= known;
    row_result     <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    frames_sent++;
  endtask

  // Stops offering and waits until every frame sent so far has come back.
  // The first edge makes sure the last accepted frame is already queued.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Both channels are sampled at the rising edge, before any of this edge's
  // updates land. The output side is handled first so that a request can
  // never be matched against the frame taken at the same edge.
  always @(posedge clk_i) begin : monitor
    decoded_t want;
    if (!rst_ni) begin
      calib_seen   = '0;
      prev_pos     = '0;
      zero_pos     = '0;
      turn_acc     = '0;
      held_spd     = '0;
      held_cur     = '0;
      held_tmp     = '0;
      held_step    = '0;
      cnt_per_unit = mfeu_pkg::CPU_RESET;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_frames.size() == 0) begin
          note_mismatch("decoded request with no frame outstanding");
        end else begin
          check_result(pending_frames.pop_front());
        end
      end
      if (cfg_we_i) cnt_per_unit = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        want = decode_frame({pos_high_i, pos_low_i}, {speed_high_i, speed_low_i},
                            {current_high_i, current_low_i}, temperature_i);
        pending_frames.push_back(row_known ? row_result : want);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, none during the quiet stretch, and one long
  // hold-off counted here while the sender keeps offering frames.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] pos;
    logic [15:0] last_pos;
    logic [15:0] phase_cpu [N_PHASES];
    int          pick;
    int          d;
    // Divisor per random phase: the smallest nonzero one, the largest, zero, a random
    // value, a small odd one and finally the reset value again.
    phase_cpu    = '{16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd3, mfeu_pkg::CPU_RESET};
    phase_cpu[3] = 16'($urandom_range(65534, 2));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset divisor. Random capture frames fill in the
    // calibration window ahead of the row that closes it.
    for (int i = 0; i < N_VEC; i++) begin
      if (vec_tab[i].fill) begin
        while (frames_sent < CALIB_N - 1)
          offer_frame(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 1'b0, '0);
      end
      offer_frame(vec_tab[i].pos, vec_tab[i].speed, vec_tab[i].current, vec_tab[i].temp,
                  vec_tab[i].known, vec_tab[i].want);
    end
    last_pos = vec_tab[N_VEC-1].pos;

    // Random part: the divisor is changed only with the core drained.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle_block();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= phase_cpu[ph];
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_idle = (ph == 3) && (n < 100);
        if (ph == 1 && n == 40) hold_req = 1'b1;
        pick = $urandom_range(99);
        if (pick < 12) begin
          // Noise: any position word, wider than a turn most of the time.
          pos = 16'($urandom);
        end else if (pick < 24) begin
          // Steps right on either side of the half-turn wrap threshold.
          case ($urandom_range(3))
            0:       d = HALF;
            1:       d = -HALF;
            2:       d = HALF + 1;
            default: d = -HALF - 1;
          endcase
          if (int'(last_pos) + d > 65535 || int'(last_pos) + d < 0) d = -d;
          pos = 16'(int'(last_pos) + d);
        end else begin
          // Ordinary motion of a 13-bit encoder, wrapping naturally.
          d   = int'($urandom_range(1200)) - 600;
          pos = 16'((int'(last_pos) + d + TURN_CNT) % TURN_CNT);
        end
        offer_frame(pos, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0, '0);
        last_pos = pos;
      end
      no_idle = 1'b0;
    end

    settle_block();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mfeu_pkg.sv
rtl/mfeu_div.sv
rtl/motor_feedback_encoder_unwrap_core.sv
tb/sv/motor_feedback_encoder_unwrap_core_tb.sv
